FILE: rtl/av1grf_pkg.sv
// ----------------------------------------------------------------------------
// av1grf_pkg: shared definitions of the AV1 GOP reference frame tracker
// Field widths, result kinds, frame types and register indexes.
// ----------------------------------------------------------------------------
package av1grf_pkg;

  localparam int unsigned REF_DEPTH_DEF      = 8;
  localparam int unsigned BUFFER_ID_BITS_DEF = 8;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned HINT_W = 7;
  localparam int unsigned FNUM_W = 32;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned GOP_W  = 16;
  localparam int unsigned CAP_W  = 4;
  localparam int unsigned KIND_W = 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // output tdata: ftype, hint, frame number, buffer id
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_GOP_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DPB_CAPACITY = 2'd1;

  localparam logic [CAP_W-1:0] DPB_CAPACITY_RST = 4'd8;

  localparam logic FT_KEY   = 1'b0;
  localparam logic FT_INTER = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_HEADER  = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_e;

endpackage

FILE: rtl/av1_gop_reference_frame_tracker.sv
// ----------------------------------------------------------------------------
// av1_gop_reference_frame_tracker: frame type decision and reference list
// Decides key or inter per frame, keeps the short-term reference list and
// reports header, releases and the reference snapshot as a result stream.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one item per frame to encode. tuser = force_key, tdata = buffer id.
//   m_axis: result items in order: header, key-frame releases (oldest first),
//   snapshot entries oldest first ending with the current frame, then an
//   eviction release if the list was full. tlast marks the final item.
//   cfg: write gop_length (index 0) or dpb_capacity (index 1) while idle.
// Timing
//   The header is registered in the output register from S_HDR, which the
//   sequencer enters when the input item is accepted. The sequencer emits
//   one result per cycle while the receiver takes them; a stalled receiver
//   holds the output register and the sequencer waits. A frame yields N
//   result items (2..REF_DEPTH + 3). When the GOP position wraps (position
//   + 1 reaches gop_length, or gop_length was lowered below the position),
//   the bit-serial remainder unit computes the wrap. tready is high only
//   while idle.
// Reset
//   Clears the frame counter, GOP position, order hint and list count; the
//   next frame reports frame number 0 and is a key frame.
// ----------------------------------------------------------------------------
module av1_gop_reference_frame_tracker #(
  parameter int unsigned REF_DEPTH      = av1grf_pkg::REF_DEPTH_DEF,
  parameter int unsigned BUFFER_ID_BITS = av1grf_pkg::BUFFER_ID_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [av1grf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [av1grf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [av1grf_pkg::ID_W-1:0]          s_axis_tdata,  // [7:0] new_buffer_id
  input  logic                                 s_axis_tuser,  // [0] force_key
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] ftype, [7:1] hint, [39:8] frame_number, [47:40] buffer_id
  output logic [av1grf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic [av1grf_pkg::KIND_W-1:0]        m_axis_tuser,  // [1:0] kind
  output logic                                 m_axis_tlast
);

  localparam int unsigned CW = $clog2(REF_DEPTH + 1);
  localparam int unsigned IW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int unsigned ID_W = av1grf_pkg::ID_W;
  localparam int unsigned HINT_W = av1grf_pkg::HINT_W;
  localparam int unsigned POS_W = av1grf_pkg::POS_W;
  localparam int unsigned GOP_W = av1grf_pkg::GOP_W;
  localparam int unsigned DIV_W = POS_W + 1;
  localparam int unsigned DCNT_W = $clog2(DIV_W + 1);
  localparam logic [ID_W-1:0] BUF_MASK =
    (BUFFER_ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((1 << BUFFER_ID_BITS) - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_HDR    = 7'b0000010,
    S_REL    = 7'b0000100,
    S_SNAP   = 7'b0001000,
    S_CUR    = 7'b0010000,
    S_EVICT  = 7'b0100000,
    S_UPDATE = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    M_IDLE = 2'b01,
    M_RUN  = 2'b10
  } mod_state_e;

  // configuration
  logic [GOP_W-1:0]             gop_len_q;
  logic [av1grf_pkg::CAP_W-1:0] dpb_cap_q;

  // frame state
  state_e                       state_q, state_d;
  logic [POS_W-1:0]             pos_q;
  logic [av1grf_pkg::FNUM_W-1:0] fnum_q;
  logic                         first_q;
  logic [HINT_W-1:0]            hint_q;
  logic [CW-1:0]                count_q;
  logic [IW-1:0]                idx_q;
  logic                         key_q;
  logic                         evict_q;
  logic [ID_W-1:0]              newbuf_q;

  // reference list
  logic [HINT_W-1:0]            ref_hint_q [REF_DEPTH];
  logic [ID_W-1:0]              ref_buf_q  [REF_DEPTH];

  // remainder unit
  mod_state_e                   mod_state_q;
  logic [DIV_W-1:0]             div_q;
  logic [GOP_W-1:0]             rem_q;
  logic [DCNT_W-1:0]            dcnt_q;
  logic [GOP_W:0]               rem_shift;
  logic                         rem_ge;
  logic [GOP_W-1:0]             rem_next;

  // output register
  logic                         out_valid_q;
  logic [av1grf_pkg::OUT_DATA_W-1:0] out_data_q;
  logic [av1grf_pkg::KIND_W-1:0] out_kind_q;
  logic                         out_last_q;

  logic                         in_fire;
  logic                         emit_ok;
  logic                         emit;
  logic                         in_key;
  logic [CW-1:0]                cap;
  logic [CW-1:0]                cnt_eff;
  logic                         idx_end;
  logic [DIV_W-1:0]             pos_inc;
  logic                         inc_lt_len;
  logic [HINT_W-1:0]            hint_next;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign emit_ok       = !out_valid_q || m_axis_tready;
  assign in_key        = s_axis_tuser || (pos_q == '0);
  assign idx_end       = (CW'(idx_q) + CW'(1)) == count_q;
  assign pos_inc       = DIV_W'(pos_q) + DIV_W'(1);
  assign inc_lt_len    = pos_inc < DIV_W'(gop_len_q);
  assign hint_next     = hint_q + HINT_W'(1);

  assign rem_shift = {rem_q, div_q[DIV_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, gop_len_q};
  assign rem_next  = rem_ge ? GOP_W'(rem_shift - {1'b0, gop_len_q})
                            : rem_shift[GOP_W-1:0];

  always_comb begin
    if (dpb_cap_q == '0) begin
      cap = CW'(1);
    end else if ({1'b0, dpb_cap_q} > 5'(REF_DEPTH)) begin
      cap = CW'(REF_DEPTH);
    end else begin
      cap = CW'(dpb_cap_q);
    end
    cnt_eff = in_key ? '0 : count_q;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    emit    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_HDR;
      end
      S_HDR: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (count_q == '0) state_d = S_CUR;
          else if (key_q)    state_d = S_REL;
          else               state_d = S_SNAP;
        end
      end
      S_REL, S_SNAP: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (idx_end) state_d = S_CUR;
        end
      end
      S_CUR: begin
        if (emit_ok) begin
          emit    = 1'b1;
          state_d = evict_q ? S_EVICT : S_UPDATE;
        end
      end
      S_EVICT: begin
        if (emit_ok) begin
          emit    = 1'b1;
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (gop_len_q == '0 || inc_lt_len) state_d = S_IDLE;
        else if (mod_state_q == M_RUN && dcnt_q == DCNT_W'(1)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gop_len_q <= '0;
      dpb_cap_q <= av1grf_pkg::DPB_CAPACITY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        av1grf_pkg::CFG_GOP_LENGTH:   gop_len_q <= cfg_wdata_i[GOP_W-1:0];
        av1grf_pkg::CFG_DPB_CAPACITY: dpb_cap_q <= cfg_wdata_i[av1grf_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      fnum_q      <= '0;
      first_q     <= 1'b1;
      hint_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      key_q       <= 1'b0;
      evict_q     <= 1'b0;
      mod_state_q <= M_IDLE;
      dcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (first_q) first_q <= 1'b0;
            else         fnum_q  <= fnum_q + 1'b1;
            key_q   <= in_key;
            evict_q <= (cnt_eff >= cap) && (cnt_eff != '0);
            idx_q   <= '0;
            if (in_key) begin
              pos_q  <= '0;
              hint_q <= '0;
            end else begin
              hint_q <= hint_next;
            end
          end
        end
        S_REL: begin
          if (emit_ok) begin
            if (idx_end) count_q <= '0;
            else         idx_q   <= idx_q + 1'b1;
          end
        end
        S_SNAP: begin
          if (emit_ok && !idx_end) idx_q <= idx_q + 1'b1;
        end
        S_CUR: begin
          // append now; an eviction keeps the count
          if (emit_ok && !evict_q) count_q <= count_q + 1'b1;
        end
        S_UPDATE: begin
          if (gop_len_q == '0 || inc_lt_len) begin
            pos_q <= pos_inc[POS_W-1:0];
          end else if (mod_state_q == M_IDLE) begin
            mod_state_q <= M_RUN;
            dcnt_q      <= DCNT_W'(DIV_W);
          end else begin
            dcnt_q <= dcnt_q - 1'b1;
            if (dcnt_q == DCNT_W'(1)) begin
              mod_state_q <= M_IDLE;
              pos_q       <= POS_W'(rem_next);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // remainder datapath: one restoring step per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == S_UPDATE) begin
      if (mod_state_q == M_IDLE) begin
        div_q <= pos_inc;
        rem_q <= '0;
      end else begin
        div_q <= {div_q[DIV_W-2:0], 1'b0};
        rem_q <= rem_next;
      end
    end
  end

  // reference list and frame payload
  always_ff @(posedge clk_i) begin
    if (in_fire) newbuf_q <= s_axis_tdata & BUF_MASK;
    if (state_q == S_CUR && emit_ok) begin
      if (evict_q) begin
        // drop the oldest, shift down, append at the top
        for (int i = 0; i < int'(REF_DEPTH) - 1; i++) begin
          if (CW'(i + 1) != count_q) begin
            ref_hint_q[i] <= ref_hint_q[i+1];
            ref_buf_q[i]  <= ref_buf_q[i+1];
          end
        end
        ref_hint_q[IW'(count_q - CW'(1))] <= hint_q;
        ref_buf_q[IW'(count_q - CW'(1))]  <= newbuf_q;
      end else begin
        ref_hint_q[count_q[IW-1:0]] <= hint_q;
        ref_buf_q[count_q[IW-1:0]]  <= newbuf_q;
      end
    end
  end

  // eviction output is taken from entry 0 before the shift above lands,
  // so latch it at S_CUR
  logic [HINT_W-1:0] ev_hint_q;
  logic [ID_W-1:0]   ev_buf_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_CUR && emit_ok) begin
      ev_hint_q <= ref_hint_q[0];
      ev_buf_q  <= ref_buf_q[0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_last_q <= 1'b0;
      unique case (state_q)
        S_HDR: begin
          out_kind_q <= av1grf_pkg::KIND_HEADER;
          out_data_q <= {{ID_W{1'b0}}, fnum_q, hint_q,
                         key_q ? av1grf_pkg::FT_KEY : av1grf_pkg::FT_INTER};
        end
        S_REL: begin
          out_kind_q <= av1grf_pkg::KIND_RELEASE;
          out_data_q <= {ref_buf_q[idx_q], 32'd0, ref_hint_q[idx_q], 1'b0};
        end
        S_SNAP: begin
          out_kind_q <= av1grf_pkg::KIND_ENTRY;
          out_data_q <= {ref_buf_q[idx_q], 32'd0, ref_hint_q[idx_q], 1'b0};
        end
        S_CUR: begin
          out_kind_q <= av1grf_pkg::KIND_ENTRY;
          out_data_q <= {newbuf_q, 32'd0, hint_q, 1'b0};
          out_last_q <= !evict_q;
        end
        S_EVICT: begin
          out_kind_q <= av1grf_pkg::KIND_RELEASE;
          out_data_q <= {ev_buf_q, 32'd0, ev_hint_q, 1'b0};
          out_last_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // ------------------------------------------------------------------------
  // assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(REF_DEPTH))
    else $error("reference count above depth");

  a_key_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CUR && key_q) |-> (count_q == '0))
    else $error("key frame left stored references");

  a_mod_only_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_state_q == M_RUN) |-> (state_q == S_UPDATE && gop_len_q != '0))
    else $error("remainder unit running outside update");

  a_accept_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_HDR))
    else $error("accepted item did not start with header");

endmodule
